// ----- src/luma_forward_reshaper_unit_defines.svh -----
// Assertion macros for the forward luma reshaper.
// Included by the top level; no other dependencies.
`ifndef LUMA_FORWARD_RESHAPER_UNIT_DEFINES_SVH
`define LUMA_FORWARD_RESHAPER_UNIT_DEFINES_SVH

// Implication checked on the same clock edge.
`define LFR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lfr assertion failed");

// Implication checked on the following clock edge.
`define LFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lfr assertion failed");

`endif

// ----- src/lfr_pkg.sv -----
// Shared types and constants of the forward luma reshaper.
// No dependencies.
package lfr_pkg;

   localparam int NUM_PIECES  = 16;
   localparam int PIECE_IDX_W = $clog2(NUM_PIECES);

   localparam int SAMPLE_W    = 16;
   localparam int PIECE_IN_W  = 4;
   localparam int PIVOT_W     = 17;
   localparam int SCALE_W     = 16;
   localparam int BIT_DEPTH_W = 5;
   localparam int SHIFT_W     = 4;
   localparam int CSR_DATA_W  = 5;

   localparam int DIFF_W      = 18;
   localparam int PROD_W      = DIFF_W + SCALE_W;
   localparam int FRAC_BITS   = 11;
   localparam int ROUND_W     = PROD_W + 1;
   localparam int VAL_W       = 26;
   localparam int ROUND_OFFSET = 1 << (FRAC_BITS - 1);

   localparam int REQ_FIELDS_W = SAMPLE_W + PIECE_IN_W + PIVOT_W + SCALE_W + PIVOT_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W  = SAMPLE_W;

   localparam logic [BIT_DEPTH_W-1:0] BIT_DEPTH_RESET   = 5'd10;
   localparam logic [SHIFT_W-1:0]     PIECE_SHIFT_RESET = 4'd6;

   typedef enum logic [0:0] {
      OP_MAP   = 1'b0,
      OP_WRITE = 1'b1
   } op_type;

   typedef enum logic [0:0] {
      CSR_BIT_DEPTH   = 1'b0,
      CSR_PIECE_SHIFT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [PIVOT_W-1:0]        mapped_pivot;
      logic signed [SCALE_W-1:0] scale;
      logic [PIVOT_W-1:0]        input_pivot;
   } piece_type;

endpackage

// ----- src/luma_forward_reshaper_unit.sv -----
// Forward luma reshaper top level: stream ports, configuration registers.
// Depends on lfr_pkg, lfr_table, lfr_pipe and the assertion macro header.
//
// Usage:
//   req_* carries one transaction per item. req_tuser is the op: a map item
//   carries a sample and returns one mapped sample on rsp_*; a write item
//   loads one table piece and returns nothing.
//   Map results leave in order, after the five pipeline registers. One item is
//   taken per cycle while the output does not stall; the pipeline has five stages
//   (lookup, difference, 16x18 product, rounding add, clip), each stage one register.
//   A piece written by a write item is seen by every later map item.
//   csr_* writes bit_depth (index 0) or piece_shift (index 1); the user must
//   do so only while idle, which the block does not enforce. Reset clears
//   all valid bits and loads bit_depth 10, piece_shift 6; the table is
//   undefined until written. When rsp_tready is low, results fill the
//   pipeline bubbles first; req_tready drops only when every stage holds an item.
`include "luma_forward_reshaper_unit_defines.svh"
module luma_forward_reshaper_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // sample, piece_index, new_mapped_pivot, new_scale, new_input_pivot, zero pad
   input  logic [lfr_pkg::REQ_TDATA_W-1:0] req_tdata,
   // op
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // mapped_sample
   output logic [lfr_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [lfr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import lfr_pkg::*;

   localparam int PIECE_LO  = SAMPLE_W;
   localparam int MAPPED_LO = PIECE_LO + PIECE_IN_W;
   localparam int SCALE_LO  = MAPPED_LO + PIVOT_W;
   localparam int INPUT_LO  = SCALE_LO + SCALE_W;

   logic [BIT_DEPTH_W-1:0]  bit_depth_ff;
   logic [SHIFT_W-1:0]      piece_shift_ff;
   logic [SAMPLE_W:0]       max_wide;
   logic [SAMPLE_W-1:0]     max_sample;
   logic [SAMPLE_W-1:0]     sample;
   logic [PIECE_IN_W-1:0]   piece_index;
   piece_type               wr_piece, rd_piece;
   logic                    is_map, wr_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_depth_ff   <= BIT_DEPTH_RESET;
         piece_shift_ff <= PIECE_SHIFT_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_BIT_DEPTH:   bit_depth_ff   <= csr_wdata[BIT_DEPTH_W-1:0];
            CSR_PIECE_SHIFT: piece_shift_ff <= csr_wdata[SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      max_wide = ((SAMPLE_W + 1)'(1) << bit_depth_ff) - (SAMPLE_W + 1)'(1);
      if (bit_depth_ff >= BIT_DEPTH_W'(SAMPLE_W)) begin
         max_sample = '1;
      end else begin
         max_sample = max_wide[SAMPLE_W-1:0];
      end
      sample                = req_tdata[SAMPLE_W-1:0];
      piece_index           = req_tdata[MAPPED_LO-1:PIECE_LO];
      wr_piece.mapped_pivot = req_tdata[SCALE_LO-1:MAPPED_LO];
      wr_piece.scale        = req_tdata[INPUT_LO-1:SCALE_LO];
      wr_piece.input_pivot  = req_tdata[INPUT_LO+PIVOT_W-1:INPUT_LO];
      is_map                = (op_type'(req_tuser) == OP_MAP);
      wr_en                 = req_tvalid && req_tready && !is_map;
   end

   lfr_table u_table (
      .clock       (clock),
      .wr_en       (wr_en),
      .wr_index    (piece_index),
      .wr_piece    (wr_piece),
      .sample      (sample),
      .piece_shift (piece_shift_ff),
      .rd_piece    (rd_piece)
   );

   lfr_pipe u_pipe (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid && is_map),
      .in_ready   (req_tready),
      .in_sample  (sample),
      .in_piece   (rd_piece),
      .max_sample (max_sample),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_sample (rsp_tdata)
   );

   `LFR_ASSERT_SAME(a_out_in_range, clock, reset, rsp_tvalid, rsp_tdata <= max_sample)
   `LFR_ASSERT_SAME(a_stall_from_output, clock, reset, !req_tready,
                    rsp_tvalid && !rsp_tready)
   `LFR_ASSERT_NEXT(a_hold_on_stall, clock, reset, rsp_tvalid && !rsp_tready,
                    rsp_tvalid && $stable(rsp_tdata))

endmodule

// ----- src/lfr_table.sv -----
// Piece table of the forward luma reshaper: write port and piece lookup.
// Depends on lfr_pkg.
module lfr_table (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [lfr_pkg::PIECE_IN_W-1:0] wr_index,
   input  lfr_pkg::piece_type            wr_piece,
   input  logic [lfr_pkg::SAMPLE_W-1:0]  sample,
   input  logic [lfr_pkg::SHIFT_W-1:0]   piece_shift,
   output lfr_pkg::piece_type            rd_piece
);
   import lfr_pkg::*;

   piece_type                pieces_ff [NUM_PIECES];
   logic [SAMPLE_W-1:0]      shifted;
   logic [PIECE_IDX_W-1:0]   rd_index;

   always_comb begin
      shifted = sample >> piece_shift;
      if (shifted > SAMPLE_W'(NUM_PIECES - 1)) begin
         rd_index = PIECE_IDX_W'(NUM_PIECES - 1);
      end else begin
         rd_index = shifted[PIECE_IDX_W-1:0];
      end
      rd_piece = pieces_ff[rd_index];
   end

   always_ff @(posedge clock) begin
      if (wr_en && (int'(wr_index) < NUM_PIECES)) begin
         pieces_ff[PIECE_IDX_W'(wr_index)] <= wr_piece;
      end
   end

endmodule

// ----- src/lfr_pipe.sv -----
// Five-stage mapping pipeline: lookup register, difference, product, rounding add, clip.
// Depends on lfr_pkg.
module lfr_pipe (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [lfr_pkg::SAMPLE_W-1:0] in_sample,
   input  lfr_pkg::piece_type           in_piece,
   input  logic [lfr_pkg::SAMPLE_W-1:0] max_sample,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [lfr_pkg::SAMPLE_W-1:0] out_sample
);
   import lfr_pkg::*;

   localparam int STAGES = 5;

   logic [STAGES-1:0] valid_ff, valid_in, rdy;

   logic [SAMPLE_W-1:0]        sample1_ff;
   piece_type                  piece1_ff;
   logic signed [DIFF_W-1:0]   diff2_ff, diff2_in;
   logic [PIVOT_W-1:0]         mapped2_ff, mapped3_ff;
   logic signed [SCALE_W-1:0]  scale2_ff;
   logic signed [PROD_W-1:0]   prod3_ff, prod3_in;
   logic signed [VAL_W-1:0]    val4_ff, val4_in;
   logic signed [ROUND_W-1:0]  rounded;
   logic [SAMPLE_W-1:0]        out5_ff, out5_in;

   always_comb begin
      rdy[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
      valid_in[0] = rdy[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         valid_in[k] = rdy[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_comb begin
      diff2_in = $signed({2'b00, sample1_ff}) - $signed({1'b0, piece1_ff.input_pivot});
      prod3_in = PROD_W'(scale2_ff) * PROD_W'(diff2_ff);
      rounded  = ROUND_W'(prod3_ff) + ROUND_W'(ROUND_OFFSET);
      val4_in  = $signed({{(VAL_W - PIVOT_W){1'b0}}, mapped3_ff})
               + VAL_W'(rounded >>> FRAC_BITS);
      if (val4_ff[VAL_W-1]) begin
         out5_in = '0;
      end else if (val4_ff > $signed({{(VAL_W - SAMPLE_W){1'b0}}, max_sample})) begin
         out5_in = max_sample;
      end else begin
         out5_in = val4_ff[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      if (rdy[0]) begin
         sample1_ff <= in_sample;
         piece1_ff  <= in_piece;
      end
      if (rdy[1]) begin
         diff2_ff   <= diff2_in;
         mapped2_ff <= piece1_ff.mapped_pivot;
         scale2_ff  <= piece1_ff.scale;
      end
      if (rdy[2]) begin
         prod3_ff   <= prod3_in;
         mapped3_ff <= mapped2_ff;
      end
      if (rdy[3]) begin
         val4_ff <= val4_in;
      end
      if (rdy[4]) begin
         out5_ff <= out5_in;
      end
   end

   assign in_ready   = rdy[0];
   assign out_valid  = valid_ff[STAGES-1];
   assign out_sample = out5_ff;

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for luma_forward_reshaper_unit: table loads, mapped samples,
// register settings, random idle/stall mixes and a long output stall.
// Depends on lfr_pkg and the RTL of the reshaper only.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lfr_pkg::*;

   localparam int SAMPLE_LSB   = 0;
   localparam int PIECE_LSB    = SAMPLE_LSB + SAMPLE_W;
   localparam int MPIVOT_LSB   = PIECE_LSB + PIECE_IN_W;
   localparam int SCALE_LSB    = MPIVOT_LSB + PIVOT_W;
   localparam int IPIVOT_LSB   = SCALE_LSB + SCALE_W;
   localparam int PIVOT_MAX    = 65536;
   localparam int SETTLE_CYCLES = 10;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_ITEMS  = 140;

   typedef struct {
      op_type                    op;
      logic [SAMPLE_W-1:0]       sample;
      logic [PIECE_IN_W-1:0]     piece;
      logic [PIVOT_W-1:0]        mapped_pivot;
      logic signed [SCALE_W-1:0] scale;
      logic [PIVOT_W-1:0]        input_pivot;
   } reshape_item_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata = '0;
   logic                    req_tuser = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic                    csr_we = 1'b0;
   logic                    csr_index = 1'b0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   // predictor state
   logic [BIT_DEPTH_W-1:0]    cfg_bit_depth = BIT_DEPTH_RESET;
   logic [SHIFT_W-1:0]        cfg_piece_shift = PIECE_SHIFT_RESET;
   logic [PIVOT_W-1:0]        pivot_out_tbl [NUM_PIECES];
   logic signed [SCALE_W-1:0] slope_tbl [NUM_PIECES];
   logic [PIVOT_W-1:0]        pivot_in_tbl [NUM_PIECES];
   logic [SAMPLE_W-1:0]       pending_samples [$];

   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   bit          burst_toggle = 1'b0;
   int unsigned burst_len = 0;
   int unsigned error_count = 0;
   int unsigned samples_checked = 0;
   int unsigned pieces_written = 0;
   int unsigned csr_writes = 0;
   int unsigned cycle_count = 0;

   luma_forward_reshaper_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic logic [SAMPLE_W-1:0] forward_map(logic [SAMPLE_W-1:0] s);
      int unsigned idx;
      longint diff, acc, val, top;
      idx = s >> cfg_piece_shift;
      if (idx > NUM_PIECES - 1)
         idx = NUM_PIECES - 1;
      diff = longint'(s) - longint'(pivot_in_tbl[idx]);
      acc  = longint'(slope_tbl[idx]) * diff + ROUND_OFFSET;
      val  = longint'(pivot_out_tbl[idx]) + (acc >>> FRAC_BITS);
      top  = (cfg_bit_depth >= 16) ? 65535 : ((longint'(1) << cfg_bit_depth) - 1);
      if (val < 0)
         val = 0;
      if (val > top)
         val = top;
      return val[SAMPLE_W-1:0];
   endfunction

   // track accepted requests and check every accepted result
   always @(posedge clock) begin : scoreboard
      int unsigned         idx;
      logic [SAMPLE_W-1:0] want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_WRITE) begin
               idx = int'(req_tdata[PIECE_LSB +: PIECE_IN_W]);
               if (idx < NUM_PIECES) begin
                  pivot_out_tbl[idx] = req_tdata[MPIVOT_LSB +: PIVOT_W];
                  slope_tbl[idx]     = $signed(req_tdata[SCALE_LSB +: SCALE_W]);
                  pivot_in_tbl[idx]  = req_tdata[IPIVOT_LSB +: PIVOT_W];
               end
               pieces_written++;
            end else begin
               pending_samples = {pending_samples,
                                  forward_map(req_tdata[SAMPLE_LSB +: SAMPLE_W])};
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_samples.size() == 0) begin
               $error("mapped_sample: none expected, actual %0d", rsp_tdata);
               error_count++;
            end else begin
               want = pending_samples.pop_front();
               if (rsp_tdata !== want) begin
                  $error("mapped_sample mismatch: expected %0d, actual %0d", want, rsp_tdata);
                  error_count++;
               end
               samples_checked++;
            end
         end
      end
   end

   always @(negedge clock) begin : sink
      bit          burst_seen;
      int unsigned burst_left;
      if (burst_toggle != burst_seen) begin
         burst_seen = burst_toggle;
         burst_left = burst_len;
      end
      if (burst_left != 0) begin
         burst_left--;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic reshape_item_type piece_write(int unsigned i, logic [PIVOT_W-1:0] mp,
                                                    logic signed [SCALE_W-1:0] sc,
                                                    logic [PIVOT_W-1:0] ip);
      reshape_item_type it;
      it.op           = OP_WRITE;
      it.sample       = SAMPLE_W'($urandom);
      it.piece        = PIECE_IN_W'(i);
      it.mapped_pivot = mp;
      it.scale        = sc;
      it.input_pivot  = ip;
      return it;
   endfunction

   function automatic reshape_item_type map_item(logic [SAMPLE_W-1:0] s);
      reshape_item_type it;
      it              = piece_write($urandom_range(0, NUM_PIECES - 1),
                                    PIVOT_W'($urandom_range(0, PIVOT_MAX)),
                                    SCALE_W'($urandom),
                                    PIVOT_W'($urandom_range(0, PIVOT_MAX)));
      it.op           = OP_MAP;
      it.sample       = s;
      return it;
   endfunction

   // roughly monotone piece laid on the current piece grid
   function automatic reshape_item_type shaped_piece(int unsigned i);
      longint base, mp;
      base = longint'(i) << cfg_piece_shift;
      if (base > PIVOT_MAX)
         base = PIVOT_MAX;
      mp = base + $urandom_range(0, 64) - 32;
      if (mp < 0)
         mp = 0;
      if (mp > PIVOT_MAX)
         mp = PIVOT_MAX;
      return piece_write(i, PIVOT_W'(mp), SCALE_W'($urandom_range(1024, 3072)),
                         PIVOT_W'(base));
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      longint span;
      span = longint'(NUM_PIECES) << cfg_piece_shift;
      if (span > 65536)
         span = 65536;
      if ($urandom_range(0, 9) < 7)
         return SAMPLE_W'($urandom_range(0, 32'(span - 1)));
      return SAMPLE_W'($urandom);
   endfunction

   task automatic send_item(reshape_item_type it);
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = it.op;
      req_tdata  = '0;
      req_tdata[SAMPLE_LSB +: SAMPLE_W]   = it.sample;
      req_tdata[PIECE_LSB +: PIECE_IN_W]  = it.piece;
      req_tdata[MPIVOT_LSB +: PIVOT_W]    = it.mapped_pivot;
      req_tdata[SCALE_LSB +: SCALE_W]     = it.scale;
      req_tdata[IPIVOT_LSB +: PIVOT_W]    = it.input_pivot;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_samples.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      if (idx == CSR_BIT_DEPTH)
         cfg_bit_depth = value;
      else
         cfg_piece_shift = value[SHIFT_W-1:0];
      csr_writes++;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic load_shaped_table();
      for (int unsigned i = 0; i < NUM_PIECES; i++)
         send_item(shaped_piece(i));
   endtask

   task automatic test_directed_cases();
      for (int unsigned i = 0; i < NUM_PIECES; i++) begin
         case (i)
            0:       send_item(piece_write(i, 0, 32767, 0));
            3:       send_item(piece_write(i, 600, -2047, 192));
            4:       send_item(piece_write(i, 10, 3, PIVOT_W'(PIVOT_MAX)));
            15:      send_item(piece_write(i, PIVOT_W'(PIVOT_MAX), -32768,
                                           PIVOT_W'(PIVOT_MAX)));
            default: send_item(piece_write(i, PIVOT_W'(i << 6), 2048, PIVOT_W'(i << 6)));
         endcase
      end
      send_item(map_item(0));
      send_item(map_item(63));
      send_item(map_item(100));
      send_item(map_item(193));
      send_item(map_item(256));
      send_item(map_item(960));
      send_item(map_item(16'hFFFF));
      wait_for_results();
      write_register(CSR_BIT_DEPTH, 16);
      send_item(map_item(16'hFFFF));
      send_item(map_item(0));
      wait_for_results();
      write_register(CSR_BIT_DEPTH, 0);
      send_item(map_item(100));
      wait_for_results();
      write_register(CSR_BIT_DEPTH, 31);
      send_item(map_item(16'hFFFF));
      wait_for_results();
      write_register(CSR_BIT_DEPTH, 8);
      write_register(CSR_PIECE_SHIFT, 0);
      send_item(map_item(5));
      send_item(map_item(16'hFFFF));
      wait_for_results();
      write_register(CSR_PIECE_SHIFT, 15);
      send_item(map_item(16'hFFFF));
      send_item(map_item(16'h7FFF));
      wait_for_results();
      write_register(CSR_PIECE_SHIFT, 12);
      send_item(map_item(16'h3007));
      send_item(map_item(16'hF000));
      wait_for_results();
   endtask

   task automatic test_random_phase(int unsigned sender_idle, int unsigned sink_stall);
      logic [CSR_DATA_W-1:0] depth, shift;
      int unsigned           roll;
      reshape_item_type      it;
      wait_for_results();
      idle_pct  = sender_idle;
      stall_pct = sink_stall;
      roll = $urandom_range(0, 9);
      if (roll < 8)
         depth = CSR_DATA_W'($urandom_range(8, 16));
      else if (roll == 8)
         depth = CSR_DATA_W'($urandom_range(17, 31));
      else
         depth = CSR_DATA_W'($urandom_range(0, 7));
      shift = ($urandom_range(0, 9) < 8) ? CSR_DATA_W'($urandom_range(0, 12))
                                         : CSR_DATA_W'($urandom_range(13, 15));
      write_register(CSR_BIT_DEPTH, depth);
      write_register(CSR_PIECE_SHIFT, shift);
      load_shaped_table();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 85)
            it = map_item(pick_sample());
         else if (roll < 96)
            it = shaped_piece($urandom_range(0, NUM_PIECES - 1));
         else
            it = piece_write($urandom_range(0, NUM_PIECES - 1),
                             PIVOT_W'($urandom_range(0, PIVOT_MAX)),
                             SCALE_W'($urandom),
                             PIVOT_W'($urandom_range(0, PIVOT_MAX)));
         send_item(it);
      end
      wait_for_results();
   endtask

   task automatic test_output_stall();
      idle_pct  = 0;
      stall_pct = 0;
      wait_for_results();
      burst_len    = 150;
      burst_toggle = ~burst_toggle;
      for (int n = 0; n < 40; n++)
         send_item(map_item(pick_sample()));
      wait_for_results();
      for (int n = 0; n < 5; n++)
         send_item(map_item(pick_sample()));
      wait_for_results();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_cases();
      test_random_phase(0, 0);
      test_random_phase(48, 0);
      test_random_phase(0, 48);
      test_random_phase(17, 17);
      test_output_stall();
      wait_for_results();
      $display("Checked %0d mapped samples after %0d piece writes and %0d register writes,",
               samples_checked, pieces_written, csr_writes);
      $display("under four idle/stall mixes and one long output stall.");
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
